[hw/rtl/dfr_pkg.sv]
// Shared constants, types and helpers for the differing-run finder.
package dfr_pkg;

   localparam int MAX_RUN = 16;
   localparam int BYTE_W  = 8;
   localparam int PAIR_W  = 2 * BYTE_W;
   localparam int POS_W   = 32;
   localparam int CFG_W   = 5;
   localparam int RUN_W   = $clog2(MAX_RUN + 2);
   localparam int LEN_W   = $clog2(MAX_RUN + 1);
   localparam int ADDR_W  = (MAX_RUN > 1) ? $clog2(MAX_RUN) : 1;

   localparam logic [CFG_W-1:0] RUN_LENGTH_RESET = CFG_W'(1);

   // Emission request handed from the scanner to the emitter
   typedef struct packed {
      logic             valid;
      logic             found;
      logic [POS_W-1:0] position;
      logic [LEN_W-1:0] len;
   } cmd_type;

   function automatic logic [POS_W-1:0] sat_inc(input logic [POS_W-1:0] v);
      sat_inc = (v == '1) ? v : v + POS_W'(1);
   endfunction

endpackage

[hw/rtl/dfr_req_if.sv]
// Input channel: one old/new byte pair per transfer.
interface dfr_req_if;
   logic                       valid;
   logic                       ready;
   logic [dfr_pkg::BYTE_W-1:0] old_byte;
   logic [dfr_pkg::BYTE_W-1:0] new_byte;
   logic                       end_of_stream;

   modport source (output valid, output old_byte, output new_byte, output end_of_stream,
                   input ready);
   modport sink   (input valid, input old_byte, input new_byte, input end_of_stream,
                   output ready);
endinterface

[hw/rtl/dfr_rsp_if.sv]
// Result channel: one stored run pair or a not-found marker per transfer.
interface dfr_rsp_if;
   logic                       valid;
   logic                       ready;
   logic                       found;
   logic [dfr_pkg::BYTE_W-1:0] old_value;
   logic [dfr_pkg::BYTE_W-1:0] new_value;
   logic [dfr_pkg::POS_W-1:0]  position;
   logic                       last_result;

   modport source (output valid, output found, output old_value, output new_value,
                   output position, output last_result, input ready);
   modport sink   (input valid, input found, input old_value, input new_value,
                   input position, input last_result, output ready);
endinterface

[hw/rtl/dfr_ram.sv]
// Generic simple dual-port RAM with registered read data.
module dfr_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  logic                                          clock,
   input  logic                                          wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  wr_addr,
   input  logic [WIDTH-1:0]                              wr_data,
   input  logic                                          rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  rd_addr,
   output logic [WIDTH-1:0]                              rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/dfr_scan.sv]
// Scanner: tracks the differing run and stream position, writes run pairs to the store.
module dfr_scan (
   input  logic                         clock,
   input  logic                         reset,
   dfr_req_if.sink                      req,
   input  logic                         csr_wr_en,
   input  logic [dfr_pkg::CFG_W-1:0]    csr_wr_data,
   input  logic                         emit_busy,
   output dfr_pkg::cmd_type             cmd,
   output logic                         ram_wr_en,
   output logic [dfr_pkg::ADDR_W-1:0]   ram_wr_addr,
   output logic [dfr_pkg::PAIR_W-1:0]   ram_wr_data
);

   logic [dfr_pkg::CFG_W-1:0] run_length_ff, run_length_in;
   logic [dfr_pkg::RUN_W-1:0] run_count_ff, run_count_in;
   logic [dfr_pkg::POS_W-1:0] pair_count_ff, pair_count_in;
   logic                      matched_ff, matched_in;

   logic                      accept;
   logic                      differ;
   logic                      len_ok;
   logic [dfr_pkg::RUN_W-1:0] run_count_inc;
   logic [dfr_pkg::POS_W-1:0] pair_count_inc;

   // Hold input while the emitter drains a run or a not-found result
   assign req.ready = !emit_busy;
   assign accept    = req.valid && req.ready;
   assign differ    = (req.old_byte != req.new_byte);
   assign len_ok    = (run_length_ff != '0) && (int'(run_length_ff) <= dfr_pkg::MAX_RUN);

   assign run_count_inc  = (int'(run_count_ff) < dfr_pkg::MAX_RUN + 1) ?
                           run_count_ff + dfr_pkg::RUN_W'(1) : run_count_ff;
   assign pair_count_inc = dfr_pkg::sat_inc(pair_count_ff);

   assign ram_wr_en   = accept && !matched_ff && differ &&
                        (int'(run_count_ff) < dfr_pkg::MAX_RUN);
   assign ram_wr_addr = run_count_ff[dfr_pkg::ADDR_W-1:0];
   assign ram_wr_data = {req.old_byte, req.new_byte};

   always_comb begin
      run_length_in = csr_wr_en ? csr_wr_data : run_length_ff;
      run_count_in  = run_count_ff;
      pair_count_in = pair_count_ff;
      matched_in    = matched_ff;
      cmd           = '0;

      if (accept) begin
         if (matched_ff) begin
            if (req.end_of_stream) begin
               run_count_in  = '0;
               pair_count_in = '0;
               matched_in    = 1'b0;
            end
         end else begin
            if (differ) begin
               run_count_in = run_count_inc;
               // A run cut off by the stream end counts the last pair
               if (req.end_of_stream && len_ok &&
                   int'(run_count_inc) == int'(run_length_ff)) begin
                  cmd.valid    = 1'b1;
                  cmd.found    = 1'b1;
                  cmd.position = pair_count_inc;
                  cmd.len      = dfr_pkg::LEN_W'(run_length_ff);
               end
            end else begin
               run_count_in = '0;
               if (len_ok && int'(run_count_ff) == int'(run_length_ff)) begin
                  cmd.valid    = 1'b1;
                  cmd.found    = 1'b1;
                  cmd.position = pair_count_ff;
                  cmd.len      = dfr_pkg::LEN_W'(run_length_ff);
                  matched_in   = 1'b1;
               end
            end

            if (req.end_of_stream) begin
               if (!cmd.valid) begin
                  cmd.valid    = 1'b1;
                  cmd.found    = 1'b0;
                  cmd.position = pair_count_inc;
                  cmd.len      = dfr_pkg::LEN_W'(1);
               end
               run_count_in  = '0;
               pair_count_in = '0;
               matched_in    = 1'b0;
            end else begin
               pair_count_in = pair_count_inc;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_length_ff <= dfr_pkg::RUN_LENGTH_RESET;
         run_count_ff  <= '0;
         pair_count_ff <= '0;
         matched_ff    <= 1'b0;
      end else begin
         run_length_ff <= run_length_in;
         run_count_ff  <= run_count_in;
         pair_count_ff <= pair_count_in;
         matched_ff    <= matched_in;
      end
   end

endmodule

[hw/rtl/dfr_emit.sv]
// Emitter: reads a stored run back one pair a cycle unless the result channel stalls, and drives the result register.
module dfr_emit (
   input  logic                         clock,
   input  logic                         reset,
   input  dfr_pkg::cmd_type             cmd,
   output logic                         busy,
   output logic                         ram_rd_en,
   output logic [dfr_pkg::ADDR_W-1:0]   ram_rd_addr,
   input  logic [dfr_pkg::PAIR_W-1:0]   ram_rd_data,
   dfr_rsp_if.source                    rsp
);

   typedef enum logic {IDLE, READ} state_type;

   state_type                  state_ff, state_in;
   logic                       found_ff, found_in;
   logic [dfr_pkg::POS_W-1:0]  pos_ff, pos_in;
   logic [dfr_pkg::LEN_W-1:0]  len_ff, len_in;
   logic [dfr_pkg::ADDR_W-1:0] cnt_ff, cnt_in;

   // Beat in flight through the RAM read stage
   logic                       pend_ff, pend_in;
   logic                       pend_found_ff, pend_found_in;
   logic                       pend_last_ff, pend_last_in;
   logic [dfr_pkg::POS_W-1:0]  pend_pos_ff, pend_pos_in;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       rsp_found_ff, rsp_found_in;
   logic [dfr_pkg::BYTE_W-1:0] rsp_old_ff, rsp_old_in;
   logic [dfr_pkg::BYTE_W-1:0] rsp_new_ff, rsp_new_in;
   logic [dfr_pkg::POS_W-1:0]  rsp_pos_ff, rsp_pos_in;
   logic                       rsp_last_ff, rsp_last_in;

   logic                       out_load;
   logic                       issue;
   logic                       issue_last;

   assign out_load   = pend_ff && (!rsp_valid_ff || rsp.ready);
   assign issue      = (state_ff == READ) && (!pend_ff || out_load);
   assign issue_last = (int'(cnt_ff) + 1 == int'(len_ff));

   assign busy        = (state_ff == READ);
   assign ram_rd_en   = issue && found_ff;
   assign ram_rd_addr = cnt_ff;

   always_comb begin
      state_in      = state_ff;
      found_in      = found_ff;
      pos_in        = pos_ff;
      len_in        = len_ff;
      cnt_in        = cnt_ff;
      pend_in       = pend_ff;
      pend_found_in = pend_found_ff;
      pend_last_in  = pend_last_ff;
      pend_pos_in   = pend_pos_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_old_in    = rsp_old_ff;
      rsp_new_in    = rsp_new_ff;
      rsp_pos_in    = rsp_pos_ff;
      rsp_last_in   = rsp_last_ff;

      unique case (state_ff)
         IDLE: begin
            if (cmd.valid) begin
               state_in = READ;
               found_in = cmd.found;
               pos_in   = cmd.position;
               len_in   = cmd.len;
               cnt_in   = '0;
            end
         end
         READ: begin
            if (issue) begin
               cnt_in = cnt_ff + dfr_pkg::ADDR_W'(1);
               if (issue_last) begin
                  state_in = IDLE;
               end
            end
         end
         default: state_in = IDLE;
      endcase

      if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (out_load) begin
         pend_in      = 1'b0;
         rsp_valid_in = 1'b1;
         rsp_found_in = pend_found_ff;
         rsp_old_in   = pend_found_ff ? ram_rd_data[dfr_pkg::PAIR_W-1:dfr_pkg::BYTE_W] : '0;
         rsp_new_in   = pend_found_ff ? ram_rd_data[dfr_pkg::BYTE_W-1:0] : '0;
         rsp_pos_in   = pend_pos_ff;
         rsp_last_in  = pend_last_ff;
      end
      if (issue) begin
         pend_in       = 1'b1;
         pend_found_in = found_ff;
         pend_last_in  = issue_last;
         pend_pos_in   = pos_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      found_ff      <= found_in;
      pos_ff        <= pos_in;
      len_ff        <= len_in;
      cnt_ff        <= cnt_in;
      pend_found_ff <= pend_found_in;
      pend_last_ff  <= pend_last_in;
      pend_pos_ff   <= pend_pos_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_old_ff    <= rsp_old_in;
      rsp_new_ff    <= rsp_new_in;
      rsp_pos_ff    <= rsp_pos_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.found       = rsp_found_ff;
   assign rsp.old_value   = rsp_old_ff;
   assign rsp.new_value   = rsp_new_ff;
   assign rsp.position    = rsp_pos_ff;
   assign rsp.last_result = rsp_last_ff;

endmodule

[hw/rtl/diff_run_finder.sv]
// Throughput: one byte pair per cycle while no result is pending emission.
// A found run blocks input while the store is read back pair by pair through its
// single read port; a not-found result blocks input until the emitter issues it.
// A first result passes the emitter state, store read and result registers in turn.
// Reset (synchronous): run_length returns to 1, counters and match flag clear;
// the run store is not cleared and is only read at entries of the current run.
module diff_run_finder (
   input  logic                      clock,
   input  logic                      reset,
   dfr_req_if.sink                   req_chan,
   dfr_rsp_if.source                 rsp_chan,
   input  logic                      csr_wr_en,
   input  logic [dfr_pkg::CFG_W-1:0] csr_wr_data
);

   dfr_pkg::cmd_type             cmd;
   logic                         emit_busy;
   logic                         ram_wr_en;
   logic [dfr_pkg::ADDR_W-1:0]   ram_wr_addr;
   logic [dfr_pkg::PAIR_W-1:0]   ram_wr_data;
   logic                         ram_rd_en;
   logic [dfr_pkg::ADDR_W-1:0]   ram_rd_addr;
   logic [dfr_pkg::PAIR_W-1:0]   ram_rd_data;

   dfr_scan u_scan (
      .clock       (clock),
      .reset       (reset),
      .req         (req_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .emit_busy   (emit_busy),
      .cmd         (cmd),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data)
   );

   dfr_ram #(
      .WIDTH (dfr_pkg::PAIR_W),
      .DEPTH (dfr_pkg::MAX_RUN)
   ) u_run_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   dfr_emit u_emit (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .busy        (emit_busy),
      .ram_rd_en   (ram_rd_en),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data),
      .rsp         (rsp_chan)
   );

   // A not-found result is a single final transfer with zero data
   a_not_found_final: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.found |->
         rsp_chan.last_result && rsp_chan.old_value == '0 && rsp_chan.new_value == '0)
      else $error("not-found result malformed");

   // The store is never written while a run is being read back
   a_no_write_during_read: assert property (@(posedge clock) disable iff (reset)
      emit_busy |-> !ram_wr_en)
      else $error("run store written during readback");

   // Emission requests only come from an accepted transfer
   a_cmd_on_accept: assert property (@(posedge clock) disable iff (reset)
      cmd.valid |-> req_chan.valid && req_chan.ready)
      else $error("emission request without input transfer");

   // An emission request starts the emitter on the next cycle
   a_cmd_starts_emit: assert property (@(posedge clock) disable iff (reset)
      cmd.valid |=> emit_busy)
      else $error("emitter did not start");

endmodule

[verif/diff_run_checker.sv]
// Channel monitor for diff_run_finder: predicts each result and compares it on transfer.
`timescale 1ns / 1ps
module diff_run_checker
   import dfr_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   dfr_req_if               req_mon,
   dfr_rsp_if               rsp_mon,
   input  logic             csr_wr_en,
   input  logic [CFG_W-1:0] csr_wr_data,
   output int               mismatch_count,
   output int               results_due,
   output int               pairs_scanned
);

   typedef struct packed {
      logic              found;
      logic [BYTE_W-1:0] old_value;
      logic [BYTE_W-1:0] new_value;
      logic [POS_W-1:0]  position;
      logic              last_result;
   } run_pair_type;

   run_pair_type      pairs_due[$];
   logic [CFG_W-1:0]  want_len;
   logic [RUN_W-1:0]  run_cnt;
   logic [POS_W-1:0]  pair_cnt;
   logic              skip_rest;
   logic [PAIR_W-1:0] run_pairs[MAX_RUN];
   int                errs = 0;
   int                scanned = 0;

   function automatic logic [POS_W-1:0] next_count(input logic [POS_W-1:0] v);
      return (v == '1) ? v : v + 1'b1;
   endfunction

   function automatic void restart_stream();
      run_cnt   = '0;
      pair_cnt  = '0;
      skip_rest = 1'b0;
   endfunction

   // Queue the stored pairs of the current run, oldest first.
   function automatic void queue_run(input logic [POS_W-1:0] pos);
      run_pair_type r;
      for (int k = 0; k < want_len; k++) begin
         r.found       = 1'b1;
         r.old_value   = run_pairs[k][PAIR_W-1:BYTE_W];
         r.new_value   = run_pairs[k][BYTE_W-1:0];
         r.position    = pos;
         r.last_result = (k == want_len - 1);
         pairs_due.insert(pairs_due.size(), r);
      end
   endfunction

   task automatic scan_pair(input logic [BYTE_W-1:0] ob, input logic [BYTE_W-1:0] nb,
                            input logic eos);
      logic         len_ok;
      logic         emitted;
      run_pair_type none;
      len_ok  = (want_len >= 1) && (want_len <= MAX_RUN);
      emitted = 1'b0;
      scanned++;
      if (skip_rest) begin
         // drop everything up to the end of the stream
         if (eos) restart_stream();
      end else begin
         if (ob != nb) begin
            if (run_cnt < MAX_RUN) run_pairs[run_cnt] = {ob, nb};
            if (run_cnt <= MAX_RUN) run_cnt++;
            if (eos && len_ok && run_cnt == want_len) begin
               queue_run(next_count(pair_cnt));
               emitted = 1'b1;
            end
         end else begin
            if (len_ok && run_cnt == want_len) begin
               queue_run(pair_cnt);
               emitted   = 1'b1;
               skip_rest = 1'b1;
            end
            run_cnt = '0;
         end
         if (eos) begin
            if (!emitted) begin
               none.found       = 1'b0;
               none.old_value   = '0;
               none.new_value   = '0;
               none.position    = next_count(pair_cnt);
               none.last_result = 1'b1;
               pairs_due.insert(pairs_due.size(), none);
            end
            restart_stream();
         end else begin
            pair_cnt = next_count(pair_cnt);
         end
      end
   endtask

   always @(posedge clock) begin : watch
      run_pair_type got;
      run_pair_type want;
      if (reset) begin
         want_len = RUN_LENGTH_RESET;
         restart_stream();
         pairs_due.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            got = {rsp_mon.found, rsp_mon.old_value, rsp_mon.new_value,
                   rsp_mon.position, rsp_mon.last_result};
            if (pairs_due.size() == 0) begin
               errs++;
               if (errs <= 10)
                  $display("%0t: result with none expected: found=%0b old=%02h new=%02h",
                           $time, got.found, got.old_value, got.new_value,
                           " pos=%0d last=%0b", got.position, got.last_result);
            end else begin
               want = pairs_due.pop_front();
               if (got !== want) begin
                  errs++;
                  if (errs <= 10) begin
                     $display("%0t: mismatch exp found=%0b old=%02h new=%02h pos=%0d last=%0b",
                              $time, want.found, want.old_value, want.new_value,
                              want.position, want.last_result);
                     $display("        got found=%0b old=%02h new=%02h pos=%0d last=%0b",
                              got.found, got.old_value, got.new_value, got.position,
                              got.last_result);
                  end
               end
            end
         end
         if (req_mon.valid && req_mon.ready)
            scan_pair(req_mon.old_byte, req_mon.new_byte, req_mon.end_of_stream);
         // a write applies from the next transfer on
         if (csr_wr_en) want_len = csr_wr_data;
      end
      results_due    <= pairs_due.size();
      mismatch_count <= errs;
      pairs_scanned  <= scanned;
   end

endmodule

[verif/diff_run_finder_tb.sv]
// Top-level testbench for diff_run_finder: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module diff_run_finder_tb;
   import dfr_pkg::*;

   logic             clock;
   logic             reset;
   logic             csr_wr_en;
   logic [CFG_W-1:0] csr_wr_data;
   logic [CFG_W-1:0] cur_len;
   int               mismatch_count;
   int               results_due;
   int               pairs_scanned;
   int               send_idle_pct = 19;
   int               recv_idle_pct = 71;
   int               hold_asks = 0;

   dfr_req_if req_chan();
   dfr_rsp_if rsp_chan();

   diff_run_finder DUT (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   diff_run_checker run_watch (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_chan),
      .rsp_mon        (rsp_chan),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .mismatch_count (mismatch_count),
      .results_due    (results_due),
      .pairs_scanned  (pairs_scanned)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("[diff_run_finder] ERROR");
      $finish;
   end

   // Result side: random back-pressure, plus a long hold-off on request.
   initial begin : receiver
      int hold_left;
      int hold_seen;
      hold_left = 0;
      hold_seen = 0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_asks != hold_seen) begin
            hold_seen = hold_asks;
            hold_left = 80;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   task automatic send_pair(input logic [BYTE_W-1:0] ob, input logic [BYTE_W-1:0] nb,
                            input logic eos);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid         <= 1'b1;
      req_chan.old_byte      <= ob;
      req_chan.new_byte      <= nb;
      req_chan.end_of_stream <= eos;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
   endtask

   // Hold the input until every pending result has come out and the pipe is empty.
   task automatic wait_quiet();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (results_due != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_run_length(input logic [CFG_W-1:0] len);
      wait_quiet();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= len;
      cur_len = len;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // One stream: equal gaps and differing runs sized around the run length.
   task automatic send_stream(input logic [CFG_W-1:0] len);
      logic [PAIR_W-1:0] pairs[$];
      logic [BYTE_W-1:0] ob;
      int                segs;
      int                run;
      segs = $urandom_range(1, 3);
      for (int s = 0; s < segs; s++) begin
         repeat ($urandom_range(0, 2)) begin
            ob = BYTE_W'($urandom);
            pairs.insert(pairs.size(), {ob, ob});
         end
         case ($urandom_range(9))
            0, 1, 2, 3, 4: run = len;
            5:             run = len + 1;
            6:             run = len - 1;
            default:       run = $urandom_range(1, 4);
         endcase
         if (run < 1 || run > MAX_RUN + 2) run = $urandom_range(1, MAX_RUN + 2);
         repeat (run) begin
            ob = BYTE_W'($urandom);
            if ($urandom_range(9) == 0)
               pairs.insert(pairs.size(), PAIR_W'($urandom));
            else
               pairs.insert(pairs.size(), {ob, ob ^ BYTE_W'($urandom_range(1, 255))});
         end
      end
      if ($urandom_range(1) == 1) begin
         ob = BYTE_W'($urandom);
         pairs.insert(pairs.size(), {ob, ob});
      end
      foreach (pairs[i])
         send_pair(pairs[i][PAIR_W-1:BYTE_W], pairs[i][BYTE_W-1:0], i == pairs.size() - 1);
   endtask

   task automatic run_phase(input int s_pct, input int r_pct, input logic [CFG_W-1:0] len,
                            input logic hold, input int goal);
      int target;
      wait_quiet();
      send_idle_pct <= s_pct;
      recv_idle_pct <= r_pct;
      set_run_length(len);
      if (hold) hold_asks <= hold_asks + 1;
      target = pairs_scanned + goal;
      while (pairs_scanned < target) begin
         if ($urandom_range(3) == 0) begin
            case ($urandom_range(9))
               0:       set_run_length('0);
               1:       set_run_length(CFG_W'($urandom_range(MAX_RUN + 1, 31)));
               2:       set_run_length(CFG_W'(MAX_RUN));
               default: set_run_length(CFG_W'($urandom_range(1, 6)));
            endcase
         end
         send_stream(cur_len);
      end
   endtask

   initial begin
      reset                  <= 1'b1;
      csr_wr_en              <= 1'b0;
      csr_wr_data            <= '0;
      req_chan.valid         <= 1'b0;
      req_chan.old_byte      <= '0;
      req_chan.new_byte      <= '0;
      req_chan.end_of_stream <= 1'b0;
      cur_len = RUN_LENGTH_RESET;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // length of one out of reset: a lone equal pair finds nothing
      send_pair(8'hFF, 8'hFF, 1'b1);
      // match at an equal pair, then the rest of the stream is dropped
      send_pair(8'h00, 8'hFF, 1'b0);
      send_pair(8'hAA, 8'hAA, 1'b0);
      send_pair(8'h12, 8'h34, 1'b0);
      send_pair(8'hFF, 8'h00, 1'b1);
      // longer run skipped, single differing last pair matches at stream end
      send_pair(8'h01, 8'h02, 1'b0);
      send_pair(8'h03, 8'h04, 1'b0);
      send_pair(8'h05, 8'h05, 1'b0);
      send_pair(8'h06, 8'h07, 1'b1);
      set_run_length(5'd2);
      send_pair(8'h11, 8'h22, 1'b1);
      // out-of-range lengths never match
      set_run_length(5'd0);
      send_pair(8'h01, 8'h00, 1'b0);
      send_pair(8'h02, 8'h00, 1'b1);
      set_run_length(5'd17);
      send_pair(8'h80, 8'h7F, 1'b0);
      send_pair(8'h80, 8'h80, 1'b1);
      set_run_length(5'd31);
      send_pair(8'h00, 8'h01, 1'b1);
      // change the length mid-stream; the run count carries over
      set_run_length(5'd2);
      send_pair(8'h01, 8'h02, 1'b0);
      set_run_length(5'd1);
      send_pair(8'h03, 8'h03, 1'b0);
      send_pair(8'h04, 8'h04, 1'b1);

      run_phase(19, 71, CFG_W'(MAX_RUN), 1'b0, 35);
      run_phase(71, 19, 5'd1, 1'b0, 35);
      run_phase(0, 0, 5'd3, 1'b1, 35);

      wait_quiet();
      if (mismatch_count == 0 && results_due == 0)
         $display("[diff_run_finder] OK");
      else
         $display("[diff_run_finder] ERROR");
      $finish;
   end

endmodule

[filelist.f]
hw/rtl/dfr_pkg.sv
hw/rtl/dfr_req_if.sv
hw/rtl/dfr_rsp_if.sv
hw/rtl/dfr_ram.sv
hw/rtl/dfr_scan.sv
hw/rtl/dfr_emit.sv
hw/rtl/diff_run_finder.sv
verif/diff_run_checker.sv
verif/diff_run_finder_tb.sv
